/* src/tcmm_pkg.sv */
// ----------------------------------------------------------------------------
// tcmm_pkg
// Shared types and constants of the three channel matrix multiplier.
// ----------------------------------------------------------------------------
package tcmm_pkg;

   localparam int MAX_DIM    = 8;
   localparam int DIM_BITS   = 3;
   localparam int DEPTH      = MAX_DIM * MAX_DIM;
   localparam int ADDR_BITS  = 2 * DIM_BITS;
   localparam int VALUE_BITS = 16;
   localparam int ELEM_BITS  = 3 * VALUE_BITS;
   localparam int PROD_BITS  = 2 * VALUE_BITS;
   localparam int ACC_BITS   = 35;
   localparam int SUM_BITS   = 34;
   localparam int SIZE_BITS  = 4;

   localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(MAX_DIM);

   localparam logic [1:0] ACT_PIXEL   = 2'd0;
   localparam logic [1:0] ACT_FILTER  = 2'd1;
   localparam logic [1:0] ACT_COMPUTE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } tcmm_state_type;

   typedef struct packed {
      logic valid;
      logic first;
   } tcmm_mac_ctrl_type;

   typedef struct packed {
      logic                push;
      logic [DIM_BITS-1:0] row;
      logic [DIM_BITS-1:0] column;
      logic                last;
   } tcmm_push_type;

endpackage

/* src/tcmm_store.sv */
// ----------------------------------------------------------------------------
// tcmm_store
// One matrix store: a write port and a registered read port.
// ----------------------------------------------------------------------------
module tcmm_store (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [tcmm_pkg::ADDR_BITS-1:0] wr_addr,
   input  logic [tcmm_pkg::ELEM_BITS-1:0] wr_data,
   input  logic [tcmm_pkg::ADDR_BITS-1:0] rd_addr,
   output logic [tcmm_pkg::ELEM_BITS-1:0] rd_data
);

   logic [tcmm_pkg::ELEM_BITS-1:0] mem_ff [tcmm_pkg::DEPTH];
   logic [tcmm_pkg::ELEM_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/tcmm_lane.sv */
// ----------------------------------------------------------------------------
// tcmm_lane
// Multiply-accumulate lane for one color channel.
// ----------------------------------------------------------------------------
module tcmm_lane (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tcmm_pkg::tcmm_mac_ctrl_type            ctrl,
   input  logic signed [tcmm_pkg::VALUE_BITS-1:0] pixel,
   input  logic signed [tcmm_pkg::VALUE_BITS-1:0] filter,
   output logic signed [tcmm_pkg::ACC_BITS-1:0]   acc
);

   logic signed [tcmm_pkg::PROD_BITS-1:0] prod_ff;
   logic signed [tcmm_pkg::PROD_BITS-1:0] prod_in;
   tcmm_pkg::tcmm_mac_ctrl_type           prod_ctrl_ff;
   logic signed [tcmm_pkg::ACC_BITS-1:0]  acc_ff;
   logic signed [tcmm_pkg::ACC_BITS-1:0]  acc_in;
   logic signed [tcmm_pkg::ACC_BITS-1:0]  prod_ext;

   assign prod_in  = pixel * filter;
   assign prod_ext = tcmm_pkg::ACC_BITS'(prod_ff);

   always_comb begin
      acc_in = acc_ff;
      if (prod_ctrl_ff.valid) begin
         acc_in = prod_ctrl_ff.first ? prod_ext : acc_ff + prod_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ctrl_ff <= '0;
      end else begin
         prod_ctrl_ff <= ctrl;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

/* src/tcmm_merge.sv */
// ----------------------------------------------------------------------------
// tcmm_merge
// Merges the three lane sums into one result item, saturates each sum and
// holds the item in the output register.
// ----------------------------------------------------------------------------
module tcmm_merge (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tcmm_pkg::tcmm_push_type               push,
   input  logic signed [tcmm_pkg::ACC_BITS-1:0]  acc_first,
   input  logic signed [tcmm_pkg::ACC_BITS-1:0]  acc_second,
   input  logic signed [tcmm_pkg::ACC_BITS-1:0]  acc_third,
   output logic                                  out_free,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [tcmm_pkg::DIM_BITS-1:0]         rsp_out_row,
   output logic [tcmm_pkg::DIM_BITS-1:0]         rsp_out_column,
   output logic signed [tcmm_pkg::SUM_BITS-1:0]  rsp_sum_first,
   output logic signed [tcmm_pkg::SUM_BITS-1:0]  rsp_sum_second,
   output logic signed [tcmm_pkg::SUM_BITS-1:0]  rsp_sum_third,
   output logic                                  rsp_last
);

   function automatic logic [tcmm_pkg::SUM_BITS-1:0] saturate(
      input logic [tcmm_pkg::ACC_BITS-1:0] value
   );
      logic [tcmm_pkg::SUM_BITS-1:0] result;
      if (value[tcmm_pkg::ACC_BITS-1] != value[tcmm_pkg::SUM_BITS-1]) begin
         result = {value[tcmm_pkg::ACC_BITS-1], {(tcmm_pkg::SUM_BITS-1){
                   ~value[tcmm_pkg::ACC_BITS-1]}}};
      end else begin
         result = value[tcmm_pkg::SUM_BITS-1:0];
      end
      return result;
   endfunction

   logic                          valid_ff;
   logic                          valid_in;
   logic [tcmm_pkg::DIM_BITS-1:0] row_ff;
   logic [tcmm_pkg::DIM_BITS-1:0] column_ff;
   logic [tcmm_pkg::SUM_BITS-1:0] first_ff;
   logic [tcmm_pkg::SUM_BITS-1:0] second_ff;
   logic [tcmm_pkg::SUM_BITS-1:0] third_ff;
   logic                          last_ff;

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      if (push.push) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push) begin
         row_ff    <= push.row;
         column_ff <= push.column;
         last_ff   <= push.last;
         first_ff  <= saturate(acc_first);
         second_ff <= saturate(acc_second);
         third_ff  <= saturate(acc_third);
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_row    = row_ff;
   assign rsp_out_column = column_ff;
   assign rsp_sum_first  = first_ff;
   assign rsp_sum_second = second_ff;
   assign rsp_sum_third  = third_ff;
   assign rsp_last       = last_ff;

endmodule

/* src/three_channel_matrix_multiply.sv */
// ----------------------------------------------------------------------------
// three_channel_matrix_multiply
// Per-channel square matrix product of a pixel matrix and a filter matrix.
//
//   Channel   Ports         Direction   Moves
//   req       req_*         in          load or compute item
//   rsp       rsp_*         out         one product element per item
//   csr       csr_*         in          size_in_use register write
//
// A compute item emits n*n result items, n being the clamped size in use;
// each is built from reads, one per k, from the single read port of each
// store, which pass through the read, multiply and accumulate registers
// and then the output register.
// Reset clears control state only; the stores are not cleared.
// A stalled output holds the sequencer before it starts the next element.
// ----------------------------------------------------------------------------
module three_channel_matrix_multiply (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_action,
   input  logic [tcmm_pkg::DIM_BITS-1:0]         req_row,
   input  logic [tcmm_pkg::DIM_BITS-1:0]         req_column,
   input  logic signed [tcmm_pkg::VALUE_BITS-1:0] req_value_first,
   input  logic signed [tcmm_pkg::VALUE_BITS-1:0] req_value_second,
   input  logic signed [tcmm_pkg::VALUE_BITS-1:0] req_value_third,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [tcmm_pkg::DIM_BITS-1:0]         rsp_out_row,
   output logic [tcmm_pkg::DIM_BITS-1:0]         rsp_out_column,
   output logic signed [tcmm_pkg::SUM_BITS-1:0]  rsp_sum_first,
   output logic signed [tcmm_pkg::SUM_BITS-1:0]  rsp_sum_second,
   output logic signed [tcmm_pkg::SUM_BITS-1:0]  rsp_sum_third,
   output logic                                  rsp_last,
   input  logic                                  csr_write_enable,
   input  logic [tcmm_pkg::SIZE_BITS-1:0]        csr_write_data
);

   tcmm_pkg::tcmm_state_type        state_ff;
   tcmm_pkg::tcmm_state_type        state_in;
   logic [tcmm_pkg::SIZE_BITS-1:0]  size_ff;
   logic [tcmm_pkg::DIM_BITS-1:0]   size_m1;
   logic [tcmm_pkg::DIM_BITS-1:0]   nm1_ff;
   logic [tcmm_pkg::DIM_BITS-1:0]   nm1_in;
   logic [tcmm_pkg::DIM_BITS-1:0]   i_ff;
   logic [tcmm_pkg::DIM_BITS-1:0]   i_in;
   logic [tcmm_pkg::DIM_BITS-1:0]   j_ff;
   logic [tcmm_pkg::DIM_BITS-1:0]   j_in;
   logic [tcmm_pkg::DIM_BITS-1:0]   k_ff;
   logic [tcmm_pkg::DIM_BITS-1:0]   k_in;
   logic                            accept;
   logic                            issue;
   logic                            issue_last;
   tcmm_pkg::tcmm_mac_ctrl_type     rd_ctrl_ff;
   tcmm_pkg::tcmm_mac_ctrl_type     rd_ctrl_in;
   logic                            rd_last_ff;
   logic                            prod_last_ff;
   logic                            sum_ready_ff;
   logic                            sum_ready_in;
   tcmm_pkg::tcmm_push_type         push;
   logic                            out_free;
   logic [tcmm_pkg::ADDR_BITS-1:0]  wr_addr;
   logic [tcmm_pkg::ELEM_BITS-1:0]  wr_data;
   logic [tcmm_pkg::ELEM_BITS-1:0]  pixel_data;
   logic [tcmm_pkg::ELEM_BITS-1:0]  filter_data;
   logic signed [tcmm_pkg::ACC_BITS-1:0] acc_first;
   logic signed [tcmm_pkg::ACC_BITS-1:0] acc_second;
   logic signed [tcmm_pkg::ACC_BITS-1:0] acc_third;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != tcmm_pkg::ST_IDLE);
   assign wr_addr   = {req_row, req_column};
   assign wr_data   = {req_value_third, req_value_second, req_value_first};

   always_comb begin
      priority if (size_ff == '0) begin
         size_m1 = '0;
      end else if (size_ff >= tcmm_pkg::SIZE_BITS'(tcmm_pkg::MAX_DIM)) begin
         size_m1 = tcmm_pkg::DIM_BITS'(tcmm_pkg::MAX_DIM - 1);
      end else begin
         size_m1 = tcmm_pkg::DIM_BITS'(size_ff - tcmm_pkg::SIZE_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= tcmm_pkg::SIZE_RESET;
      end else if (csr_write_enable) begin
         size_ff <= csr_write_data;
      end
   end

   always_comb begin
      state_in    = state_ff;
      nm1_in      = nm1_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      issue       = 1'b0;
      issue_last  = 1'b0;
      push        = '0;
      push.row    = i_ff;
      push.column = j_ff;
      push.last   = (i_ff == nm1_ff) && (j_ff == nm1_ff);
      unique case (state_ff)
         tcmm_pkg::ST_IDLE: begin
            if (accept && req_action == tcmm_pkg::ACT_COMPUTE) begin
               nm1_in   = size_m1;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               state_in = tcmm_pkg::ST_ISSUE;
            end
         end
         tcmm_pkg::ST_ISSUE: begin
            issue      = 1'b1;
            issue_last = (k_ff == nm1_ff);
            if (issue_last) begin
               k_in     = '0;
               state_in = tcmm_pkg::ST_DRAIN;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         tcmm_pkg::ST_DRAIN: begin
            if (sum_ready_ff && out_free) begin
               push.push = 1'b1;
               if (push.last) begin
                  state_in = tcmm_pkg::ST_IDLE;
               end else begin
                  state_in = tcmm_pkg::ST_ISSUE;
                  if (j_ff == nm1_ff) begin
                     j_in = '0;
                     i_in = i_ff + 1'b1;
                  end else begin
                     j_in = j_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = tcmm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rd_ctrl_in.valid = issue;
      rd_ctrl_in.first = issue && (k_ff == '0);
      sum_ready_in     = sum_ready_ff;
      if (prod_last_ff) begin
         sum_ready_in = 1'b1;
      end else if (push.push) begin
         sum_ready_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcmm_pkg::ST_IDLE;
         rd_ctrl_ff   <= '0;
         rd_last_ff   <= 1'b0;
         prod_last_ff <= 1'b0;
         sum_ready_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ctrl_ff   <= rd_ctrl_in;
         rd_last_ff   <= issue_last;
         prod_last_ff <= rd_last_ff;
         sum_ready_ff <= sum_ready_in;
      end
   end

   always_ff @(posedge clock) begin
      nm1_ff <= nm1_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
      k_ff   <= k_in;
   end

   tcmm_store u_pixel_store (
      .clock   (clock),
      .wr_en   (accept && req_action == tcmm_pkg::ACT_PIXEL),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr ({i_ff, k_ff}),
      .rd_data (pixel_data)
   );

   tcmm_store u_filter_store (
      .clock   (clock),
      .wr_en   (accept && req_action == tcmm_pkg::ACT_FILTER),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr ({k_ff, j_ff}),
      .rd_data (filter_data)
   );

   tcmm_lane u_lane_first (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (rd_ctrl_ff),
      .pixel  (pixel_data[tcmm_pkg::VALUE_BITS-1:0]),
      .filter (filter_data[tcmm_pkg::VALUE_BITS-1:0]),
      .acc    (acc_first)
   );

   tcmm_lane u_lane_second (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (rd_ctrl_ff),
      .pixel  (pixel_data[2*tcmm_pkg::VALUE_BITS-1:tcmm_pkg::VALUE_BITS]),
      .filter (filter_data[2*tcmm_pkg::VALUE_BITS-1:tcmm_pkg::VALUE_BITS]),
      .acc    (acc_second)
   );

   tcmm_lane u_lane_third (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (rd_ctrl_ff),
      .pixel  (pixel_data[3*tcmm_pkg::VALUE_BITS-1:2*tcmm_pkg::VALUE_BITS]),
      .filter (filter_data[3*tcmm_pkg::VALUE_BITS-1:2*tcmm_pkg::VALUE_BITS]),
      .acc    (acc_third)
   );

   tcmm_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .acc_first      (acc_first),
      .acc_second     (acc_second),
      .acc_third      (acc_third),
      .out_free       (out_free),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_column (rsp_out_column),
      .rsp_sum_first  (rsp_sum_first),
      .rsp_sum_second (rsp_sum_second),
      .rsp_sum_third  (rsp_sum_third),
      .rsp_last       (rsp_last)
   );

endmodule

/* src/tcmm_checker.sv */
// ----------------------------------------------------------------------------
// tcmm_checker
// Port-level checks of the three channel matrix multiplier.
// ----------------------------------------------------------------------------
module tcmm_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [tcmm_pkg::DIM_BITS-1:0]         rsp_out_row,
   input logic [tcmm_pkg::DIM_BITS-1:0]         rsp_out_column,
   input logic signed [tcmm_pkg::SUM_BITS-1:0]  rsp_sum_first,
   input logic                                  rsp_last
);

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result item valid right after reset.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sum_first))
      else $error("Stalled result item dropped or changed.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("Input accepted while a compute run is still emitting.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_out_row == rsp_out_column)
      else $error("Final item of a run is not on the diagonal corner.");

endmodule

bind three_channel_matrix_multiply tcmm_checker u_tcmm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_out_row    (rsp_out_row),
   .rsp_out_column (rsp_out_column),
   .rsp_sum_first  (rsp_sum_first),
   .rsp_last       (rsp_last)
);
